// ===== rtl/dlle_pkg.sv =====
// Shared constants, codes and the cell command type of the linked list engine.
package dlle_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;
  localparam int VAL_W    = 32;
  localparam int REQ_W    = 3;
  localparam int ST_W     = 2;
  localparam int CNT_OUT_W = 6;

  localparam logic [REQ_W-1:0] REQ_PUSH_HEAD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_TAIL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_HEAD  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_TAIL  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DUMP      = 3'd5;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

  localparam logic [1:0] OP_HOLD     = 2'd0;
  localparam logic [1:0] OP_PUSH_AT  = 2'd1;
  localparam logic [1:0] OP_POP_HEAD = 2'd2;
  localparam logic [1:0] OP_ROTATE   = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic [CMP_W-1:0]        pos;
    logic [CMP_W-1:0]        tail_idx;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/dlle_req_if.sv =====
// Request channel: valid, ready and the request payload.
interface dlle_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [dlle_pkg::REQ_W-1:0]             req_type;
  logic signed [dlle_pkg::VAL_W-1:0]      value;
  logic [dlle_pkg::POS_W-1:0]             position;

  modport source (output valid, req_type, value, position, input ready);
  modport sink (input valid, req_type, value, position, output ready);
endinterface

// ===== rtl/dlle_res_if.sv =====
// Result channel: valid, ready and the result payload.
interface dlle_res_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [dlle_pkg::VAL_W-1:0]      out_value;
  logic                                   has_value;
  logic [dlle_pkg::CNT_OUT_W-1:0]         entry_count;
  logic [dlle_pkg::ST_W-1:0]              status;
  logic                                   last;

  modport source (output valid, out_value, has_value, entry_count, status, last,
                  input ready);
  modport sink (input valid, out_value, has_value, entry_count, status, last,
                output ready);
endinterface

// ===== rtl/dlle_cell.sv =====
// One list cell: holds the element at its index and moves with its neighbours.
module dlle_cell (
  input  logic                              clk,
  input  dlle_pkg::cell_cmd_t               cmd,
  input  logic [dlle_pkg::IDX_W-1:0]        idx,
  input  logic signed [dlle_pkg::VAL_W-1:0] left_val,
  input  logic signed [dlle_pkg::VAL_W-1:0] right_val,
  input  logic signed [dlle_pkg::VAL_W-1:0] head_val,
  output logic signed [dlle_pkg::VAL_W-1:0] val
);

  logic signed [dlle_pkg::VAL_W-1:0] val_next;
  logic [dlle_pkg::CMP_W-1:0]        my_idx;

  assign my_idx = dlle_pkg::CMP_W'(idx);

  always_comb begin
    val_next = val;
    case (cmd.op)
      dlle_pkg::OP_PUSH_AT: begin
        if (my_idx == cmd.pos) begin
          val_next = cmd.value;
        end else if (my_idx > cmd.pos) begin
          val_next = left_val;
        end
      end
      dlle_pkg::OP_POP_HEAD: val_next = right_val;
      dlle_pkg::OP_ROTATE: begin
        if (my_idx == cmd.tail_idx) begin
          val_next = head_val;
        end else if (my_idx < cmd.tail_idx) begin
          val_next = right_val;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== rtl/doubly_linked_list_engine_unit.sv =====
// Top level of the linked list engine: request decode, cell row and result register.
//
//   channel | dir | payload
//   req     | in  | req_type, value, position
//   res     | out | out_value, has_value, entry_count, status, last
//
// Push, insert and delete requests each give one result.
// A dump gives no result on acceptance, then one result per element (32 at most):
// the row rotates once per result and cell 0 is emitted.
// Synchronous reset empties the list at once; no clearing pass is needed.
// A stalled result holds the row; a new request is taken once the result register frees and no dump runs.
module doubly_linked_list_engine_unit (
  input logic         clk,
  input logic         rst,
  dlle_req_if.sink    req,
  dlle_res_if.source  res
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                                state;
  logic                                state_next;
  logic [dlle_pkg::COUNT_W-1:0]        count;
  logic [dlle_pkg::COUNT_W-1:0]        count_next;
  logic [dlle_pkg::COUNT_W-1:0]        remaining;
  logic [dlle_pkg::COUNT_W-1:0]        remaining_next;
  logic                                res_valid;
  logic                                res_load;
  logic signed [dlle_pkg::VAL_W-1:0]   out_value;
  logic signed [dlle_pkg::VAL_W-1:0]   out_value_next;
  logic                                has_value;
  logic                                has_value_next;
  logic [dlle_pkg::ST_W-1:0]           status;
  logic [dlle_pkg::ST_W-1:0]           status_next;
  logic                                last;
  logic                                last_next;
  logic                                out_free;
  logic                                accept;
  logic                                full;
  logic [dlle_pkg::CMP_W-1:0]          count_cmp;
  logic [dlle_pkg::CMP_W-1:0]          pos_cmp;
  dlle_pkg::cell_cmd_t                 cmd;
  logic signed [dlle_pkg::VAL_W-1:0]   cell_val [dlle_pkg::CAPACITY];

  assign out_free  = !res_valid || res.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign full      = (count == dlle_pkg::COUNT_W'(dlle_pkg::CAPACITY));
  assign count_cmp = dlle_pkg::CMP_W'(count);
  assign pos_cmp   = dlle_pkg::CMP_W'(req.position);

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    res_load       = 1'b0;
    out_value_next = '0;
    has_value_next = 1'b0;
    status_next    = dlle_pkg::ST_OK;
    last_next      = 1'b1;
    cmd.op         = dlle_pkg::OP_HOLD;
    cmd.pos        = '0;
    cmd.tail_idx   = count_cmp - dlle_pkg::CMP_W'(1);
    cmd.value      = req.value;

    if (state == S_IDLE) begin
      if (accept) begin
        res_load = 1'b1;
        case (req.req_type)
          dlle_pkg::REQ_PUSH_HEAD: begin
            if (full) begin
              status_next = dlle_pkg::ST_FULL;
            end else begin
              cmd.op     = dlle_pkg::OP_PUSH_AT;
              cmd.pos    = '0;
              count_next = count + dlle_pkg::COUNT_W'(1);
            end
          end
          dlle_pkg::REQ_PUSH_TAIL: begin
            if (full) begin
              status_next = dlle_pkg::ST_FULL;
            end else begin
              cmd.op     = dlle_pkg::OP_PUSH_AT;
              cmd.pos    = count_cmp;
              count_next = count + dlle_pkg::COUNT_W'(1);
            end
          end
          dlle_pkg::REQ_INSERT: begin
            if (pos_cmp > count_cmp) begin
              status_next = dlle_pkg::ST_BADPOS;
            end else if (full) begin
              status_next = dlle_pkg::ST_FULL;
            end else begin
              cmd.op     = dlle_pkg::OP_PUSH_AT;
              cmd.pos    = pos_cmp;
              count_next = count + dlle_pkg::COUNT_W'(1);
            end
          end
          dlle_pkg::REQ_DEL_HEAD: begin
            if (count == '0) begin
              status_next = dlle_pkg::ST_EMPTY;
            end else begin
              cmd.op     = dlle_pkg::OP_POP_HEAD;
              count_next = count - dlle_pkg::COUNT_W'(1);
            end
          end
          dlle_pkg::REQ_DEL_TAIL: begin
            if (count == '0) begin
              status_next = dlle_pkg::ST_EMPTY;
            end else begin
              count_next = count - dlle_pkg::COUNT_W'(1);
            end
          end
          dlle_pkg::REQ_DUMP: begin
            if (count == '0) begin
              status_next = dlle_pkg::ST_EMPTY;
            end else begin
              res_load       = 1'b0;
              state_next     = S_DUMP;
              remaining_next = count;
            end
          end
          default: status_next = dlle_pkg::ST_OK;
        endcase
      end
    end else if (out_free) begin
      cmd.op         = dlle_pkg::OP_ROTATE;
      res_load       = 1'b1;
      out_value_next = cell_val[0];
      has_value_next = 1'b1;
      last_next      = (remaining == dlle_pkg::COUNT_W'(1));
      remaining_next = remaining - dlle_pkg::COUNT_W'(1);
      if (last_next) begin
        state_next = S_IDLE;
      end
    end
  end

  for (genvar i = 0; i < dlle_pkg::CAPACITY; i++) begin : g_cell
    logic signed [dlle_pkg::VAL_W-1:0] left_val;
    logic signed [dlle_pkg::VAL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == dlle_pkg::CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    dlle_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (dlle_pkg::IDX_W'(i)),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (cell_val[0]),
      .val       (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_value <= out_value_next;
      has_value <= has_value_next;
      status    <= status_next;
      last      <= last_next;
    end
  end

  logic [dlle_pkg::CNT_OUT_W-1:0] entry_count;

  always_ff @(posedge clk) begin
    if (res_load) begin
      entry_count <= dlle_pkg::CNT_OUT_W'(count_next);
    end
  end

  assign res.valid       = res_valid;
  assign res.out_value   = out_value;
  assign res.has_value   = has_value;
  assign res.entry_count = entry_count;
  assign res.status      = status;
  assign res.last        = last;

endmodule
